FILE: rtl/core/swr_pkg.sv
// Shared types and constants for the stop-and-wait reply controller.
// No dependencies; every module of the block imports this package.
package swr_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [8:0]  COUNT_MAX   = 9'd511;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CODE_NONE        = 3'd0,
      CSR_CODE_READ_SENSOR = 3'd1,
      CSR_CODE_ABORT       = 3'd2,
      CSR_CODE_HUMID_TEMP  = 3'd3,
      CSR_CODE_GAS         = 3'd4
   } swr_csr_index_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_SEND   = 2'd1,
      ACT_RESEND = 2'd2,
      ACT_ABORT  = 2'd3
   } swr_action_type;

   typedef enum logic {
      FUNC_MESSAGE = 1'b0,
      FUNC_TIMER   = 1'b1
   } swr_func_type;

   typedef struct packed {
      logic [0:0] func;
      logic [7:0] request;
      logic [7:0] sequence_req;
      logic [7:0] fail_limit;
      logic [7:0] ack_flag;
      logic [7:0] sensor_type;
      logic [7:0] check_value;
      logic [0:0] sensor_ok;
   } swr_req_type;

   typedef struct packed {
      swr_action_type action;
      logic [7:0]     send_type;
      logic [7:0]     send_seq;
      logic [0:0]     timer_start;
      logic [0:0]     timer_stop;
   } swr_rsp_type;

   typedef struct packed {
      logic [7:0] code_none;
      logic [7:0] code_read_sensor;
      logic [7:0] code_abort;
      logic [7:0] code_humid_temp;
      logic [7:0] code_gas;
   } swr_cfg_type;

   typedef struct packed {
      logic       waiting_ack;
      logic [7:0] pending_seq;
      logic [7:0] pending_type;
      logic [8:0] timeout_count;
      logic [7:0] timeout_limit;
   } swr_state_type;

endpackage

FILE: rtl/core/stop_and_wait_reply_controller.sv
// Top level of the stop-and-wait reply controller: code registers, exchange
// state, result register and skid stage. Depends on swr_pkg and swr_decide.
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall  swr_req_type
//   rsp_      out         rsp_valid/rsp_stall  swr_rsp_type
//   csr_      in          csr_valid/csr_ready  csr_index, csr_wdata
//
// One request per cycle while req_stall is low; its result is registered in the
// result register, or in the skid stage when the output is stalled. The state
// update is a single combinational pass (swr_decide). reset clears the exchange
// state and valid flags and restores the default codes. A stalled result parks
// one more result in the skid stage; req_stall rises only when that stage is full.
module stop_and_wait_reply_controller import swr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  swr_req_type            req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output swr_rsp_type            rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   swr_cfg_type   cfg_ff,   cfg_in;
   swr_state_type state_ff, state_in;
   swr_state_type state_calc;
   swr_rsp_type   result;
   swr_rsp_type   out_ff,   out_in;
   swr_rsp_type   skid_ff,  skid_in;
   logic          out_valid_ff,  out_valid_in;
   logic          skid_valid_ff, skid_valid_in;
   logic          req_acc;
   logic          rsp_acc;

   swr_decide u_decide (
      .item       (req_data),
      .state      (state_ff),
      .cfg        (cfg_ff),
      .result     (result),
      .state_next (state_calc)
   );

   assign req_stall = skid_valid_ff;
   assign req_acc   = req_valid && !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign rsp_acc   = out_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CODE_NONE:        cfg_in.code_none        = csr_wdata;
            CSR_CODE_READ_SENSOR: cfg_in.code_read_sensor = csr_wdata;
            CSR_CODE_ABORT:       cfg_in.code_abort       = csr_wdata;
            CSR_CODE_HUMID_TEMP:  cfg_in.code_humid_temp  = csr_wdata;
            CSR_CODE_GAS:         cfg_in.code_gas         = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      state_in      = req_acc ? state_calc : state_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_acc) begin
         // output slot frees: drain skid first, else take the new request
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (req_acc) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (req_acc) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '{code_none: 8'd0, code_read_sensor: 8'd1, code_abort: 8'd2,
                            code_humid_temp: 8'd0, code_gas: 8'd1};
         state_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

FILE: rtl/core/swr_decide.sv
// Protocol decision logic: result and next exchange state for one request.
// Purely combinational; depends on swr_pkg.
module swr_decide import swr_pkg::*; (
   input  swr_req_type   item,
   input  swr_state_type state,
   input  swr_cfg_type   cfg,
   output swr_rsp_type   result,
   output swr_state_type state_next
);

   logic [9:0] sum;
   logic       check_ok;
   logic [8:0] count_inc;
   logic       is_ht;
   logic       is_gas;
   logic       pend_known;
   logic       typ_known;

   assign sum = {2'b00, item.request} + {2'b00, item.sequence_req}
              + {2'b00, item.fail_limit} + {2'b00, item.ack_flag};
   assign check_ok  = (sum == {2'b00, item.check_value});
   assign count_inc = (state.timeout_count < COUNT_MAX) ?
                      state.timeout_count + 9'd1 : state.timeout_count;
   assign is_ht      = (item.sensor_type == cfg.code_humid_temp);
   assign is_gas     = (item.sensor_type == cfg.code_gas);
   assign typ_known  = is_ht || is_gas;
   assign pend_known = (state.pending_type == cfg.code_humid_temp)
                    || (state.pending_type == cfg.code_gas);

   always_comb begin
      result     = '{action: ACT_NONE, send_type: 8'd0, send_seq: 8'd0,
                     timer_start: 1'b0, timer_stop: 1'b0};
      state_next = state;
      if (item.func == FUNC_TIMER) begin
         if (state.waiting_ack) begin
            state_next.timeout_count = count_inc;
            if (count_inc > {1'b0, state.timeout_limit}) begin
               result.action       = ACT_ABORT;
               result.send_seq     = state.pending_seq;
               result.timer_stop   = 1'b1;
               state_next.waiting_ack = 1'b0;
            end else if (pend_known) begin
               result.action    = ACT_SEND;
               result.send_type = state.pending_type;
               result.send_seq  = state.pending_seq;
            end
         end
      end else if (!state.waiting_ack) begin
         if (!check_ok) begin
            result.action = ACT_RESEND;
         end else if (item.request == cfg.code_read_sensor && typ_known) begin
            // type is latched even when the humidity read fails
            state_next.pending_type = item.sensor_type;
            if (is_gas || item.sensor_ok[0] || !is_ht) begin
               if (!is_ht || item.sensor_ok[0]) begin
                  state_next.pending_seq   = item.sequence_req;
                  state_next.timeout_count = 9'd0;
                  state_next.timeout_limit = item.fail_limit;
                  state_next.waiting_ack   = 1'b1;
                  result.action      = ACT_SEND;
                  result.send_type   = item.sensor_type;
                  result.send_seq    = item.sequence_req;
                  result.timer_start = 1'b1;
               end
            end
         end
      end else begin
         if (!check_ok) begin
            result.action      = ACT_RESEND;
            result.timer_start = 1'b1;
         end else if (item.request == cfg.code_none && item.ack_flag != 8'd0) begin
            result.timer_stop      = 1'b1;
            state_next.waiting_ack = 1'b0;
         end else if (item.ack_flag == 8'd0 || item.request == cfg.code_read_sensor) begin
            if (typ_known) begin
               result.action    = ACT_SEND;
               result.send_type = item.sensor_type;
               result.send_seq  = state.pending_seq;
            end
            result.timer_start       = 1'b1;
            state_next.timeout_count = 9'd0;
         end else if (item.request == cfg.code_abort) begin
            result.timer_stop      = 1'b1;
            state_next.waiting_ack = 1'b0;
         end
      end
   end

endmodule

FILE: rtl/core/swr_checker.sv
// Port-level checks for the stop-and-wait reply controller, bound to the top.
// Depends on swr_pkg and stop_and_wait_reply_controller.
module swr_checker import swr_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input swr_rsp_type rsp_data
);

   // held result must not change while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // backpressure only while a result is waiting
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall without pending rsp");

   a_abort_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action == ACT_ABORT |->
         rsp_data.timer_stop == 1'b1 && rsp_data.timer_start == 1'b0)
      else $error("abort without timer stop");

   a_no_send_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.action == ACT_NONE || rsp_data.action == ACT_RESEND) |->
         rsp_data.send_type == 8'd0 && rsp_data.send_seq == 8'd0)
      else $error("fields set without a reading");

   a_start_stop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.timer_start == 1'b1 && rsp_data.timer_stop == 1'b1))
      else $error("timer start and stop together");

endmodule

bind stop_and_wait_reply_controller swr_checker u_swr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
